FILE: rtl/core/atr_stop_loss_check_top_defines.svh
// Assertion macros for the ATR stop-loss checker.
// ATR_ASSERT is disabled while reset is held; ATR_ASSERT_ALWAYS is checked on every edge.
`ifndef ATR_STOP_LOSS_CHECK_TOP_DEFINES_SVH
`define ATR_STOP_LOSS_CHECK_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ATR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ATR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ATR_ASSERT(label, prop, msg)
`define ATR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: rtl/core/atr_slc_pkg.sv
`default_nettype none

package atr_slc_pkg;

    // Fixed field widths.
    localparam int WLEN_BITS = 7;
    localparam int MULT_BITS = 16;
    localparam int QTY_BITS  = 32;
    localparam int CFG_DATA_W = 32;
    localparam int PADDR_W   = 3;

    // Result item: exit_now, then exit_qty, padded to whole bytes.
    localparam int OUT_BITS    = 1 + QTY_BITS;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Commands carried in tuser.
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    // Register indexes (address bit 2).
    localparam logic REG_WLEN = 1'b0;
    localparam logic REG_MULT = 1'b1;

    // Register reset values.
    localparam logic [WLEN_BITS-1:0] WLEN_RESET = 7'd14;
    localparam logic [MULT_BITS-1:0] MULT_RESET = 16'd512;

    typedef logic [QTY_BITS-1:0] t_qty;

endpackage

`default_nettype wire

FILE: rtl/core/atr_stop_loss_check_top.sv
// Stop check: result passes stage 1 and stage 2 and is then registered on m_tdata.
// Bar push: no result; the ring entry is read at acceptance and the range sum updated next cycle.
// Throughput: one item per cycle with write-back forwarding, unless a stalled output holds a check.
// Reset (i_rst_n low, synchronous): empty window, no previous bar, window_length 14,
// stop_multiplier 512. The ring itself is not cleared; an entry's value is used only once written.
`default_nettype none
`include "atr_stop_loss_check_top_defines.svh"

module atr_stop_loss_check_top
    import atr_slc_pkg::*;
#(
    parameter int MAX_WINDOW     = 64,
    parameter int PRICE_BITS     = 32,
    parameter int MULT_FRAC_BITS = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input item stream.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // tdata, low bit up: bar_high, bar_low, close_price, entry_price, position_qty,
    // short_side, zero fill.
    input  wire logic [((4*PRICE_BITS+QTY_BITS+1+7)/8)*8-1:0] s_tdata,
    // tuser: command.
    input  wire logic                   s_tuser,
    // Result stream.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // tdata, low bit up: exit_now, exit_qty, zero fill.
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // Configuration port.
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PADDR_W-1:0]     paddr,
    input  wire logic [CFG_DATA_W-1:0]  pwdata,
    output logic      [CFG_DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int P    = PRICE_BITS;
    localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW   = $clog2(MAX_WINDOW + 1);
    localparam int LW   = (CW > WLEN_BITS) ? CW : WLEN_BITS;
    localparam int SW   = P + CW;
    localparam int LPW  = P + CW + MULT_FRAC_BITS;
    localparam int RPW  = MULT_BITS + SW;
    localparam int CMPW = (LPW > RPW) ? LPW : RPW;

    // ---------------- configuration ----------------
    logic [WLEN_BITS-1:0] r_wl;
    logic [MULT_BITS-1:0] r_mult;
    logic                 cfg_wr;
    logic                 wl_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign wl_wr  = cfg_wr && (paddr[2] == REG_WLEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl   <= WLEN_RESET;
            r_mult <= MULT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_WLEN: r_wl   <= pwdata[WLEN_BITS-1:0];
                REG_MULT: r_mult <= pwdata[MULT_BITS-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WLEN: prdata = CFG_DATA_W'(r_wl);
            REG_MULT: prdata = CFG_DATA_W'(r_mult);
        endcase
    end

    // Effective window length: zero acts as one, anything above the ring depth as the depth.
    logic [LW-1:0] wl_ext;
    logic [CW-1:0] win_len;

    assign wl_ext = LW'(r_wl);

    always_comb begin
        priority if (wl_ext == '0) begin
            win_len = CW'(1);
        end else if (wl_ext > LW'(MAX_WINDOW)) begin
            win_len = CW'(MAX_WINDOW);
        end else begin
            win_len = CW'(wl_ext);
        end
    end

    // ---------------- input unpack ----------------
    logic [P-1:0] in_hi, in_lo, in_cl, in_entry;
    t_qty         in_qty;
    logic         in_short;

    assign in_hi    = s_tdata[P-1:0];
    assign in_lo    = s_tdata[2*P-1:P];
    assign in_cl    = s_tdata[3*P-1:2*P];
    assign in_entry = s_tdata[4*P-1:3*P];
    assign in_qty   = s_tdata[4*P+QTY_BITS-1:4*P];
    assign in_short = s_tdata[4*P+QTY_BITS];

    // ---------------- pipeline control ----------------
    logic r_s1_v, r_s1_chk;
    logic r_s2_v;
    logic r_out_v;
    logic out_en, s2_go, s1_go, accept, push_acc;

    assign out_en   = !r_out_v || m_tready;
    assign s2_go    = !r_s2_v || out_en;
    // A bar push always retires from the first stage; only a check can wait there.
    assign s1_go    = !r_s1_v || !r_s1_chk || s2_go;
    assign s_tready = s1_go;
    assign accept   = s_tvalid && s1_go;
    assign push_acc = accept && (s_tuser == CMD_PUSH);

    // ---------------- window bookkeeping at acceptance ----------------
    // Count, pointer and previous close depend only on item order, so they advance
    // when a bar push is accepted; the range sum follows in the next cycle.
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_wp;
    logic          r_have_prev;
    logic [P-1:0]  r_prev_close;

    logic [CW-1:0] n_count;
    logic [AW-1:0] n_wp;
    logic          win_full;
    logic [CW-1:0] wp_inc;

    assign win_full = (r_count >= win_len);
    assign wp_inc   = CW'(r_wp) + CW'(1);

    always_comb begin
        n_count = r_count;
        n_wp    = r_wp;
        if (push_acc && r_have_prev) begin
            n_count = win_full ? win_len : r_count + CW'(1);
            n_wp    = (wp_inc >= win_len) ? '0 : wp_inc[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_wp         <= '0;
            r_have_prev  <= 1'b0;
            r_prev_close <= '0;
        end else if (wl_wr) begin
            r_count <= '0;
            r_wp    <= '0;
        end else if (push_acc) begin
            r_count      <= n_count;
            r_wp         <= n_wp;
            r_have_prev  <= 1'b1;
            r_prev_close <= in_cl;
        end
    end

    // ---------------- stage 1 ----------------
    logic          r_s1_add, r_s1_full, r_s1_fwd, r_s1_short;
    logic [AW-1:0] r_s1_wp;
    logic [CW-1:0] r_s1_cnt;
    logic [P-1:0]  r_s1_hi, r_s1_lo, r_s1_cl, r_s1_pc, r_s1_entry;
    t_qty          r_s1_qty;
    logic [P-1:0]  r_fwd_tr;
    logic [P-1:0]  ram_rdata;
    logic          s1_push_wr;

    assign s1_push_wr = r_s1_v && !r_s1_chk && r_s1_add;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s1_chk <= 1'b0;
        end else if (s1_go) begin
            r_s1_v   <= accept;
            r_s1_chk <= accept && (s_tuser == CMD_CHECK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_add   <= r_have_prev;
            r_s1_full  <= win_full;
            r_s1_wp    <= r_wp;
            r_s1_cnt   <= n_count;
            // The entry being read was written by the push retiring at this same edge.
            r_s1_fwd   <= s1_push_wr && (r_s1_wp == r_wp);
            r_s1_hi    <= in_hi;
            r_s1_lo    <= in_lo;
            r_s1_cl    <= in_cl;
            r_s1_pc    <= r_prev_close;
            r_s1_entry <= in_entry;
            r_s1_qty   <= in_qty;
            r_s1_short <= in_short;
        end
    end

    // True range.
    logic [P-1:0] d_hp, d_lp, d_hl, tr, tr_a, old_tr;

    assign d_hp   = (r_s1_hi >= r_s1_pc) ? r_s1_hi - r_s1_pc : r_s1_pc - r_s1_hi;
    assign d_lp   = (r_s1_lo >= r_s1_pc) ? r_s1_lo - r_s1_pc : r_s1_pc - r_s1_lo;
    assign d_hl   = (r_s1_hi >= r_s1_lo) ? r_s1_hi - r_s1_lo : '0;
    assign tr_a   = (d_lp > d_hp) ? d_lp : d_hp;
    assign tr     = (d_hl > tr_a) ? d_hl : tr_a;
    assign old_tr = r_s1_fwd ? r_fwd_tr : ram_rdata;

    always_ff @(posedge i_clk) begin
        r_fwd_tr <= tr;
    end

    atr_slc_ram #(
        .WIDTH (P),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (s1_push_wr),
        .i_waddr (r_s1_wp),
        .i_wdata (tr),
        .i_re    (push_acc),
        .i_raddr (r_wp),
        .o_rdata (ram_rdata)
    );

    logic [SW-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (wl_wr) begin
            r_sum <= '0;
        end else if (s1_push_wr) begin
            r_sum <= r_sum - (r_s1_full ? SW'(old_tr) : '0) + SW'(tr);
        end
    end

    // Stop check: cross-multiplied comparison of adverse move against multiplier * ATR.
    logic [P-1:0]   adverse;
    logic           dir_ok, chk_ok;
    logic [LPW-1:0] cnt_sh, lhs;
    logic [RPW-1:0] rhs;

    always_comb begin
        if (r_s1_short) begin
            dir_ok  = (r_s1_cl >= r_s1_entry);
            adverse = r_s1_cl - r_s1_entry;
        end else begin
            dir_ok  = (r_s1_entry >= r_s1_cl);
            adverse = r_s1_entry - r_s1_cl;
        end
    end

    assign chk_ok = (r_s1_qty != '0) && (r_s1_entry != '0) && (r_s1_cnt != '0)
                    && (r_sum != '0) && dir_ok;
    assign cnt_sh = LPW'(r_s1_cnt) << MULT_FRAC_BITS;
    assign lhs    = LPW'(adverse) * cnt_sh;
    assign rhs    = RPW'(r_mult) * RPW'(r_sum);

    // ---------------- stage 2 ----------------
    logic            r_s2_ok;
    logic [CMPW-1:0] r_s2_lhs, r_s2_rhs;
    t_qty            r_s2_qty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_go) begin
            r_s2_v <= r_s1_v && r_s1_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_s2_ok  <= chk_ok;
            r_s2_lhs <= CMPW'(lhs);
            r_s2_rhs <= CMPW'(rhs);
            r_s2_qty <= r_s1_qty;
        end
    end

    // ---------------- output register ----------------
    logic hit;
    logic r_out_exit;
    t_qty r_out_qty;

    assign hit = r_s2_ok && (r_s2_lhs >= r_s2_rhs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_en) begin
            r_out_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_out_exit <= hit;
            r_out_qty  <= hit ? r_s2_qty : '0;
        end
    end

    assign m_tvalid = r_out_v;
    assign m_tdata  = OUT_TDATA_W'({r_out_qty, r_out_exit});

    // ---------------- assertions ----------------
    `ATR_ASSERT(a_wp_in_window, CW'(r_wp) < win_len, "write pointer outside window")
    `ATR_ASSERT(a_count_in_window, r_count <= win_len, "range count exceeds window")
    `ATR_ASSERT(a_exit_has_qty, (r_out_v && r_out_exit) |-> (r_out_qty != '0),
                "exit raised for a flat position")
    `ATR_ASSERT(a_fwd_only_push, (r_s1_v && r_s1_chk) |=> !s1_push_wr || !r_s1_chk,
                "ring write issued by a stop check")

endmodule

`default_nettype wire

FILE: rtl/core/atr_slc_ram.sv
`default_nettype none

module atr_slc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
